/* rtl/sfts_pkg.sv */
`timescale 1ns / 1ps
// Package for the symbol frequency table with sorted emit.
// It holds the transaction payload types, the result status codes and the controller states.
// It has no dependencies.
package sfts_pkg;

    typedef enum logic {
        CMD_COUNT  = 1'b0,
        CMD_FINISH = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_ENTRY    = 2'd0,
        STATUS_OVERFLOW = 2'd1,
        STATUS_EMPTY    = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t        command;
        logic [31:0] symbol;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] entry_symbol;
        logic [31:0] entry_count;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SCAN,
        ST_EMIT,
        ST_FINAL
    } state_t;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

endpackage

/* rtl/symbol_frequency_table_sorted.sv */
`timescale 1ns / 1ps
// Symbol frequency table: symbol and count memories, a linear search and a sorted emit.
// It depends on sfts_pkg. Count: one entry read per cycle; a search ends on a hit or after all
// held entries, and the block returns to idle before the next accept.
// Finish: each result follows a full scan of the held entries and an emit step, stalled by the output.
// Overflow and empty finish give their one result through the final state, also stalled by the output.
// Reset (synchronous, active low) clears control state and entry count; memories are not cleared.
module symbol_frequency_table_sorted #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sfts_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sfts_pkg::out_item_t m_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    logic [31:0] sym_mem [TABLE_DEPTH];
    logic [31:0] cnt_mem [TABLE_DEPTH];

    sfts_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] used_reg, used_next;
    logic             ovf_reg, ovf_next;
    logic [31:0]      sym_reg, sym_next;
    logic [CNT_W-1:0] iss_reg, iss_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [31:0]      rd_sym_reg, rd_cnt_reg;

    logic             have_prev_reg, have_prev_next;
    logic [31:0]      prev_cnt_reg, prev_cnt_next;
    logic [IDX_W-1:0] prev_idx_reg, prev_idx_next;
    logic             best_found_reg, best_found_next;
    logic [31:0]      best_cnt_reg, best_cnt_next;
    logic [31:0]      best_sym_reg, best_sym_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [CNT_W-1:0] emit_cnt_reg, emit_cnt_next;

    logic                m_valid_reg, m_valid_next;
    sfts_pkg::out_item_t m_data_reg, m_data_next;

    logic             s_fire;
    logic             out_free;
    logic             done_scan;
    logic             issue;
    logic             hit;
    logic             eligible;
    logic             emit_last;
    logic [IDX_W-1:0] rd_addr;
    logic             sym_we, cnt_we;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wr_sym, wr_cnt;

    assign s_ready   = (state_reg == sfts_pkg::ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign done_scan = !pend_reg && (iss_reg == used_reg);
    assign issue     = (iss_reg < used_reg);
    assign rd_addr   = iss_reg[IDX_W-1:0];
    assign hit       = pend_reg && (rd_sym_reg == sym_reg);
    assign eligible  = !have_prev_reg || (rd_cnt_reg < prev_cnt_reg)
                       || ((rd_cnt_reg == prev_cnt_reg) && (pend_idx_reg > prev_idx_reg));
    assign emit_last = ((emit_cnt_reg + ONE_C) == used_reg);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sfts_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.command == sfts_pkg::CMD_COUNT) begin
                        if (!ovf_reg) begin
                            state_next = sfts_pkg::ST_SEARCH;
                        end
                    end else if (ovf_reg || (used_reg == '0)) begin
                        state_next = sfts_pkg::ST_FINAL;
                    end else begin
                        state_next = sfts_pkg::ST_SCAN;
                    end
                end
            end
            sfts_pkg::ST_SEARCH: begin
                if (hit || done_scan) begin
                    state_next = sfts_pkg::ST_IDLE;
                end
            end
            sfts_pkg::ST_SCAN: begin
                if (done_scan) begin
                    state_next = sfts_pkg::ST_EMIT;
                end
            end
            sfts_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = emit_last ? sfts_pkg::ST_IDLE : sfts_pkg::ST_SCAN;
                end
            end
            sfts_pkg::ST_FINAL: begin
                if (out_free) begin
                    state_next = sfts_pkg::ST_IDLE;
                end
            end
            default: state_next = sfts_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        used_next       = used_reg;
        ovf_next        = ovf_reg;
        sym_next        = sym_reg;
        iss_next        = iss_reg;
        pend_next       = 1'b0;
        pend_idx_next   = rd_addr;
        have_prev_next  = have_prev_reg;
        prev_cnt_next   = prev_cnt_reg;
        prev_idx_next   = prev_idx_reg;
        best_found_next = best_found_reg;
        best_cnt_next   = best_cnt_reg;
        best_sym_next   = best_sym_reg;
        best_idx_next   = best_idx_reg;
        emit_cnt_next   = emit_cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        sym_we          = 1'b0;
        cnt_we          = 1'b0;
        wr_addr         = pend_idx_reg;
        wr_sym          = sym_reg;
        wr_cnt          = 32'd1;

        unique case (state_reg)
            sfts_pkg::ST_IDLE: begin
                sym_next        = s_data.symbol;
                iss_next        = '0;
                have_prev_next  = 1'b0;
                best_found_next = 1'b0;
                emit_cnt_next   = '0;
            end
            sfts_pkg::ST_SEARCH: begin
                if (hit) begin
                    cnt_we = 1'b1;
                    wr_cnt = (rd_cnt_reg == sfts_pkg::COUNT_MAX) ? rd_cnt_reg
                                                                 : rd_cnt_reg + 32'd1;
                end else if (done_scan) begin
                    if (used_reg == DEPTH_C) begin
                        ovf_next = 1'b1;
                    end else begin
                        sym_we    = 1'b1;
                        cnt_we    = 1'b1;
                        wr_addr   = used_reg[IDX_W-1:0];
                        used_next = used_reg + ONE_C;
                    end
                end else if (issue) begin
                    pend_next = 1'b1;
                    iss_next  = iss_reg + ONE_C;
                end
            end
            sfts_pkg::ST_SCAN: begin
                if (pend_reg && eligible && (!best_found_reg || (rd_cnt_reg > best_cnt_reg))) begin
                    best_found_next = 1'b1;
                    best_cnt_next   = rd_cnt_reg;
                    best_sym_next   = rd_sym_reg;
                    best_idx_next   = pend_idx_reg;
                end
                if (issue) begin
                    pend_next = 1'b1;
                    iss_next  = iss_reg + ONE_C;
                end
            end
            sfts_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.status       = sfts_pkg::STATUS_ENTRY;
                    m_data_next.entry_symbol = best_sym_reg;
                    m_data_next.entry_count  = best_cnt_reg;
                    m_data_next.last         = emit_last;
                    have_prev_next           = 1'b1;
                    prev_cnt_next            = best_cnt_reg;
                    prev_idx_next            = best_idx_reg;
                    best_found_next          = 1'b0;
                    iss_next                 = '0;
                    emit_cnt_next            = emit_cnt_reg + ONE_C;
                    if (emit_last) begin
                        used_next = '0;
                        ovf_next  = 1'b0;
                    end
                end
            end
            sfts_pkg::ST_FINAL: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.status       = ovf_reg ? sfts_pkg::STATUS_OVERFLOW
                                                       : sfts_pkg::STATUS_EMPTY;
                    m_data_next.entry_symbol = '0;
                    m_data_next.entry_count  = '0;
                    m_data_next.last         = 1'b1;
                    used_next                = '0;
                    ovf_next                 = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // table memories, one synchronous read port each on a shared address
    always_ff @(posedge aclk) begin
        if (sym_we) begin
            sym_mem[wr_addr] <= wr_sym;
        end
        if (cnt_we) begin
            cnt_mem[wr_addr] <= wr_cnt;
        end
        rd_sym_reg <= sym_mem[rd_addr];
        rd_cnt_reg <= cnt_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sfts_pkg::ST_IDLE;
            used_reg       <= '0;
            ovf_reg        <= 1'b0;
            iss_reg        <= '0;
            pend_reg       <= 1'b0;
            have_prev_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            emit_cnt_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            ovf_reg        <= ovf_next;
            iss_reg        <= iss_next;
            pend_reg       <= pend_next;
            have_prev_reg  <= have_prev_next;
            best_found_reg <= best_found_next;
            emit_cnt_reg   <= emit_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg      <= sym_next;
        pend_idx_reg <= pend_idx_next;
        prev_cnt_reg <= prev_cnt_next;
        prev_idx_reg <= prev_idx_next;
        best_cnt_reg <= best_cnt_next;
        best_sym_reg <= best_sym_next;
        best_idx_reg <= best_idx_next;
        m_data_reg   <= m_data_next;
    end

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= DEPTH_C)
        else $error("entry count beyond table depth");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (used_reg == DEPTH_C))
        else $error("overflow flagged with free entries");

    a_emit_winner: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sfts_pkg::ST_EMIT) |-> best_found_reg)
        else $error("emit without a scan winner");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sfts_pkg::ST_IDLE) |-> !pend_reg)
        else $error("read outstanding while idle");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.status != sfts_pkg::STATUS_ENTRY)) |-> m_data_reg.last)
        else $error("status transaction not marked last");

    a_emit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == sfts_pkg::ST_EMIT) && out_free && emit_last)
        |=> (used_reg == '0) && (state_reg == sfts_pkg::ST_IDLE))
        else $error("table not cleared after final entry");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for symbol_frequency_table_sorted: a directed table, then random symbol runs.
// Expected ranked entries come from an in-bench tally and stable sort. Depends on sfts_pkg.
module testbench;

    localparam int TABLE_DEPTH = 64;
    localparam int RAND_ITEMS  = 208;
    localparam int PHASE_LEN   = 40;
    localparam int N_DIR       = 22;

    typedef enum {PH_FLOW, PH_SRC_IDLE, PH_SINK_STALL, PH_BOTH} idle_phase_t;
    typedef enum {SEQ_NARROW, SEQ_WIDE, SEQ_FULL, SEQ_OVERFLOW, SEQ_EMPTY} seq_kind_t;

    typedef struct {
        sfts_pkg::cmd_t      cmd;
        logic [31:0]         sym;
        bit                  typed;
        sfts_pkg::out_item_t want;
    } dir_row_t;

    localparam sfts_pkg::out_item_t NO_WANT   = '0;
    localparam sfts_pkg::out_item_t WANT_NONE = '{sfts_pkg::STATUS_EMPTY, 32'd0, 32'd0, 1'b1};

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    sfts_pkg::in_item_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    sfts_pkg::out_item_t m_data;

    // Bench copy of the frequency table
    logic [31:0] tab_sym [TABLE_DEPTH];
    logic [31:0] tab_cnt [TABLE_DEPTH];
    int unsigned tab_used = 0;
    bit          tab_ovf = 1'b0;

    sfts_pkg::out_item_t due_entries[$];
    int unsigned         mismatch_count = 0;
    int unsigned         items_sent = 0;
    idle_phase_t         cur_phase = PH_FLOW;

    dir_row_t dir_rows [N_DIR] = '{
        '{sfts_pkg::CMD_FINISH, 32'h0000_0000, 1'b1, WANT_NONE},
        '{sfts_pkg::CMD_COUNT,  32'hFFFF_FFFF, 1'b0, NO_WANT},
        '{sfts_pkg::CMD_COUNT,  32'hFFFF_FFFF, 1'b0, NO_WANT},
        '{sfts_pkg::CMD_COUNT,  32'hFFFF_FFFF, 1'b0, NO_WANT},
        '{sfts_pkg::CMD_FINISH, 32'h1234_5678, 1'b1,
          '{sfts_pkg::STATUS_ENTRY, 32'hFFFF_FFFF, 32'd3, 1'b1}},
        '{sfts_pkg::CMD_COUNT,  32'h0000_0000, 1'b0, NO_WANT},
        '{sfts_pkg::CMD_FINISH, 32'hFFFF_FFFF, 1'b1,
          '{sfts_pkg::STATUS_ENTRY, 32'h0000_0000, 32'd1, 1'b1}},
        '{sfts_pkg::CMD_FINISH, 32'h0000_0000, 1'b1, WANT_NONE},
        '{sfts_pkg::CMD_COUNT,  32'h5555_5555, 1'b0, NO_WANT},
        '{sfts_pkg::CMD_COUNT,  32'hAAAA_AAAA, 1'b0, NO_WANT},
        '{sfts_pkg::CMD_COUNT,  32'h0000_0001, 1'b0, NO_WANT},
        '{sfts_pkg::CMD_COUNT,  32'hAAAA_AAAA, 1'b0, NO_WANT},
        '{sfts_pkg::CMD_COUNT,  32'h8000_0000, 1'b0, NO_WANT},
        '{sfts_pkg::CMD_COUNT,  32'h0000_0001, 1'b0, NO_WANT},
        '{sfts_pkg::CMD_COUNT,  32'hAAAA_AAAA, 1'b0, NO_WANT},
        '{sfts_pkg::CMD_COUNT,  32'h8000_0001, 1'b0, NO_WANT},
        '{sfts_pkg::CMD_COUNT,  32'h0000_0000, 1'b0, NO_WANT},
        '{sfts_pkg::CMD_COUNT,  32'hFFFF_FFFF, 1'b0, NO_WANT},
        '{sfts_pkg::CMD_FINISH, 32'h0000_0000, 1'b0, NO_WANT},
        '{sfts_pkg::CMD_COUNT,  32'h7FFF_FFFF, 1'b0, NO_WANT},
        '{sfts_pkg::CMD_COUNT,  32'h7FFF_FFFF, 1'b0, NO_WANT},
        '{sfts_pkg::CMD_FINISH, 32'h0000_0000, 1'b1,
          '{sfts_pkg::STATUS_ENTRY, 32'h7FFF_FFFF, 32'd2, 1'b1}}
    };

    symbol_frequency_table_sorted #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned src_idle_pct(idle_phase_t p);
        case (p)
            PH_SRC_IDLE: return 73;
            PH_BOTH:     return 36;
            default:     return 0;
        endcase
    endfunction

    function automatic int unsigned sink_stall_pct(idle_phase_t p);
        case (p)
            PH_SINK_STALL: return 73;
            PH_BOTH:       return 36;
            default:       return 0;
        endcase
    endfunction

    // Tally a symbol; on finish rank (count descending, stable) or flag overflow/empty, then clear
    function automatic void tally_and_rank(input sfts_pkg::in_item_t item,
                                           ref sfts_pkg::out_item_t ranked[$]);
        int unsigned order [TABLE_DEPTH];
        int          i;
        int          j;
        bit          hit;
        ranked.delete();
        if (item.command == sfts_pkg::CMD_COUNT) begin
            if (tab_ovf) return;
            hit = 1'b0;
            for (i = 0; i < tab_used; i++) begin
                if (!hit && tab_sym[i] == item.symbol) begin
                    hit = 1'b1;
                    if (tab_cnt[i] != sfts_pkg::COUNT_MAX) tab_cnt[i] = tab_cnt[i] + 32'd1;
                end
            end
            if (hit) return;
            if (tab_used >= TABLE_DEPTH) begin
                tab_ovf = 1'b1;
            end else begin
                tab_sym[tab_used] = item.symbol;
                tab_cnt[tab_used] = 32'd1;
                tab_used++;
            end
            return;
        end
        if (tab_ovf) begin
            ranked.push_back('{sfts_pkg::STATUS_OVERFLOW, 32'd0, 32'd0, 1'b1});
        end else if (tab_used == 0) begin
            ranked.push_back('{sfts_pkg::STATUS_EMPTY, 32'd0, 32'd0, 1'b1});
        end else begin
            for (i = 0; i < tab_used; i++) begin
                j = i;
                while (j > 0 && tab_cnt[order[j-1]] < tab_cnt[i]) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
            end
            for (i = 0; i < tab_used; i++)
                ranked.push_back('{sfts_pkg::STATUS_ENTRY, tab_sym[order[i]], tab_cnt[order[i]],
                                   (i == tab_used - 1)});
        end
        tab_used = 0;
        tab_ovf  = 1'b0;
    endfunction

    // Random symbol not yet in the pool; biased to extremes and single-bit neighbours
    function automatic logic [31:0] pick_new_symbol(ref logic [31:0] pool[$]);
        logic [31:0] s;
        bit          dup;
        do begin
            case ($urandom_range(0, 7))
                0: s = 32'h0000_0000;
                1: s = 32'hFFFF_FFFF;
                2, 3: begin
                    if (pool.size() > 0)
                        s = pool[$urandom_range(0, pool.size() - 1)]
                            ^ (32'd1 << $urandom_range(0, 31));
                    else
                        s = $urandom;
                end
                default: s = $urandom;
            endcase
            dup = 1'b0;
            foreach (pool[k])
                if (pool[k] == s) dup = 1'b1;
        end while (dup);
        return s;
    endfunction

    function automatic bit field_bad(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic push_txn(input sfts_pkg::cmd_t cmd, input logic [31:0] sym, input bit typed,
                            input sfts_pkg::out_item_t want);
        sfts_pkg::in_item_t  item;
        sfts_pkg::out_item_t ranked[$];
        item.command = cmd;
        item.symbol  = sym;
        while ($urandom_range(0, 99) < src_idle_pct(cur_phase)) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tally_and_rank(item, ranked);
        if (typed)
            due_entries.push_back(want);
        else
            foreach (ranked[r]) due_entries.push_back(ranked[r]);
        items_sent++;
        cur_phase = idle_phase_t'((items_sent / PHASE_LEN) % 4);
        @(negedge aclk);
    endtask

    always @(negedge aclk)
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct(cur_phase));

    always @(posedge aclk) begin
        sfts_pkg::out_item_t want;
        bit                  bad;
        if (aresetn && m_valid && m_ready) begin
            if (due_entries.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, m_data);
                mismatch_count++;
            end else begin
                want = due_entries.pop_front();
                bad  = field_bad("status", 32'(want.status), 32'(m_data.status));
                bad |= field_bad("entry_symbol", want.entry_symbol, m_data.entry_symbol);
                bad |= field_bad("entry_count", want.entry_count, m_data.entry_count);
                bad |= field_bad("last", 32'(want.last), 32'(m_data.last));
                if (bad) mismatch_count++;
            end
        end
    end

    initial begin
        logic [31:0] pool[$];
        seq_kind_t   kind;
        int unsigned seq_no;
        int unsigned n_sym;
        int unsigned len;
        int unsigned k;
        int unsigned pick;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[r])
            push_txn(dir_rows[r].cmd, dir_rows[r].sym, dir_rows[r].typed, dir_rows[r].want);

        seq_no = 0;
        while (items_sent < N_DIR + RAND_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (seq_no == 1)      kind = SEQ_FULL;
            else if (seq_no == 3) kind = SEQ_OVERFLOW;
            else if (pick < 10)   kind = SEQ_EMPTY;
            else if (pick < 25)   kind = SEQ_WIDE;
            else                  kind = SEQ_NARROW;
            seq_no++;
            case (kind)
                SEQ_FULL:     n_sym = TABLE_DEPTH;
                SEQ_OVERFLOW: n_sym = TABLE_DEPTH + $urandom_range(1, 3);
                SEQ_WIDE:     n_sym = $urandom_range(9, 24);
                SEQ_NARROW:   n_sym = $urandom_range(1, 8);
                default:      n_sym = 0;
            endcase
            pool.delete();
            for (k = 0; k < n_sym; k++) pool.push_back(pick_new_symbol(pool));
            if (kind == SEQ_FULL || kind == SEQ_OVERFLOW) begin
                foreach (pool[i]) push_txn(sfts_pkg::CMD_COUNT, pool[i], 1'b0, NO_WANT);
                len = $urandom_range(0, 6);
            end else begin
                len = (n_sym == 0) ? 0 : $urandom_range(n_sym, 3 * n_sym);
            end
            // skewed pick gives a spread of counts and plenty of ties
            for (k = 0; k < len; k++)
                push_txn(sfts_pkg::CMD_COUNT,
                         pool[$urandom_range(0, $urandom_range(0, n_sym - 1))],
                         1'b0, NO_WANT);
            push_txn(sfts_pkg::CMD_FINISH, $urandom, 1'b0, NO_WANT);
        end
        s_valid <= 1'b0;

        while (due_entries.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0 && due_entries.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
